// ----- rtl/lebc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_pkg
// Shared types and command codes for the line edit buffer core.
// ----------------------------------------------------------------------------
package lebc_pkg;

  typedef enum logic [3:0] {
    OP_INSERT    = 4'd0,
    OP_BACKSPACE = 4'd1,
    OP_DELETE    = 4'd2,
    OP_CLEAR     = 4'd3,
    OP_LEFT      = 4'd4,
    OP_RIGHT     = 4'd5,
    OP_HOME      = 4'd6,
    OP_END       = 4'd7,
    OP_MOVE_TO   = 4'd8,
    OP_READ      = 4'd9
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SHIFT_INS = 5'b00010,
    ST_SHIFT_DEL = 5'b00100,
    ST_PUT       = 5'b01000,
    ST_FIN       = 5'b10000
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [7:0] cursor_out;
    logic [7:0] length_out;
    logic       ok;
  } result_t;

endpackage

// ----- rtl/lebc_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_store
// Text byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lebc_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk_i,
  input  lebc_pkg::mem_ctl_t  ctl_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lebc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_ctrl
// Command sequencer: length and cursor registers, byte shift walker and
// result register.
// ----------------------------------------------------------------------------
module lebc_ctrl #(
  parameter int unsigned BUF_SIZE = 256,
  parameter int unsigned AW       = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          opcode_i,
  input  logic [7:0]          char_i,
  input  logic [7:0]          pos_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lebc_pkg::result_t   res_o,
  output lebc_pkg::mem_ctl_t  mem_ctl_o,
  output logic [AW-1:0]       waddr_o,
  output logic [7:0]          wdata_o,
  output logic [AW-1:0]       raddr_o,
  input  logic [7:0]          rdata_i
);

  localparam int unsigned   CW      = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] LastLen = AW'(BUF_SIZE - 1);
  localparam logic [AW-1:0] One     = AW'(1);

  lebc_pkg::state_e  state_q, state_d;
  lebc_pkg::op_e     op_q, op_d;
  lebc_pkg::result_t res_q, res_d;
  logic [7:0]        ch_q;
  logic [AW-1:0]     len_q, len_d, cur_q, cur_d, idx_q, idx_d;
  logic              ov_q, ov_d;
  logic              accept, load, ok_n;
  logic [7:0]        chr_n;
  logic [CW-1:0]     len_w, pos_w, len_dw, cur_dw;
  logic [AW-1:0]     idx_inc, idx_dec, cur_inc;

  assign in_ready_o = (state_q == lebc_pkg::ST_IDLE) && (!ov_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign len_w      = CW'(len_q);
  assign pos_w      = CW'(pos_i);
  assign len_dw     = CW'(len_d);
  assign cur_dw     = CW'(cur_d);
  assign idx_inc    = idx_q + One;
  assign idx_dec    = idx_q - One;
  assign cur_inc    = cur_q + One;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    len_d     = len_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    mem_ctl_o = '0;
    waddr_o   = '0;
    wdata_o   = '0;
    raddr_o   = '0;
    load      = 1'b0;
    ok_n      = 1'b0;
    chr_n     = '0;
    unique case (state_q)
      lebc_pkg::ST_IDLE: begin
        if (accept) begin
          op_d = lebc_pkg::op_e'(opcode_i);
          unique case (lebc_pkg::op_e'(opcode_i))
            lebc_pkg::OP_INSERT: begin
              if (len_q != LastLen) begin
                if (len_q != cur_q) begin
                  mem_ctl_o.re = 1'b1;
                  raddr_o      = len_q - One;
                  idx_d        = len_q - One;
                  state_d      = lebc_pkg::ST_SHIFT_INS;
                end else begin
                  state_d = lebc_pkg::ST_PUT;
                end
              end else begin
                load = 1'b1;
              end
            end
            lebc_pkg::OP_BACKSPACE: begin
              if (cur_q != '0) begin
                if (cur_q != len_q) begin
                  mem_ctl_o.re = 1'b1;
                  raddr_o      = cur_q;
                  idx_d        = cur_q;
                  state_d      = lebc_pkg::ST_SHIFT_DEL;
                end else begin
                  state_d = lebc_pkg::ST_FIN;
                end
              end else begin
                load = 1'b1;
              end
            end
            lebc_pkg::OP_DELETE: begin
              if (cur_q != len_q) begin
                if (cur_inc != len_q) begin
                  mem_ctl_o.re = 1'b1;
                  raddr_o      = cur_inc;
                  idx_d        = cur_inc;
                  state_d      = lebc_pkg::ST_SHIFT_DEL;
                end else begin
                  state_d = lebc_pkg::ST_FIN;
                end
              end else begin
                load = 1'b1;
              end
            end
            lebc_pkg::OP_CLEAR: begin
              len_d = '0;
              cur_d = '0;
              ok_n  = 1'b1;
              load  = 1'b1;
            end
            lebc_pkg::OP_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - One;
              end
              ok_n = 1'b1;
              load = 1'b1;
            end
            lebc_pkg::OP_RIGHT: begin
              if (cur_q != len_q) begin
                cur_d = cur_inc;
              end
              ok_n = 1'b1;
              load = 1'b1;
            end
            lebc_pkg::OP_HOME: begin
              cur_d = '0;
              ok_n  = 1'b1;
              load  = 1'b1;
            end
            lebc_pkg::OP_END: begin
              cur_d = len_q;
              ok_n  = 1'b1;
              load  = 1'b1;
            end
            lebc_pkg::OP_MOVE_TO: begin
              if (pos_w <= len_w) begin
                cur_d = pos_w[AW-1:0];
                ok_n  = 1'b1;
              end
              load = 1'b1;
            end
            lebc_pkg::OP_READ: begin
              if (pos_w < len_w) begin
                mem_ctl_o.re = 1'b1;
                raddr_o      = pos_w[AW-1:0];
                state_d      = lebc_pkg::ST_FIN;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      lebc_pkg::ST_SHIFT_INS: begin
        mem_ctl_o.we = 1'b1;
        waddr_o      = idx_inc;
        wdata_o      = rdata_i;
        if (idx_q != cur_q) begin
          mem_ctl_o.re = 1'b1;
          raddr_o      = idx_dec;
          idx_d        = idx_dec;
        end else begin
          state_d = lebc_pkg::ST_PUT;
        end
      end
      lebc_pkg::ST_SHIFT_DEL: begin
        mem_ctl_o.we = 1'b1;
        waddr_o      = idx_dec;
        wdata_o      = rdata_i;
        if (idx_inc != len_q) begin
          mem_ctl_o.re = 1'b1;
          raddr_o      = idx_inc;
          idx_d        = idx_inc;
        end else begin
          state_d = lebc_pkg::ST_FIN;
        end
      end
      lebc_pkg::ST_PUT: begin
        mem_ctl_o.we = 1'b1;
        waddr_o      = cur_q;
        wdata_o      = ch_q;
        state_d      = lebc_pkg::ST_FIN;
      end
      lebc_pkg::ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          load    = 1'b1;
          ok_n    = 1'b1;
          state_d = lebc_pkg::ST_IDLE;
          unique case (op_q)
            lebc_pkg::OP_INSERT: begin
              len_d = len_q + One;
              cur_d = cur_inc;
            end
            lebc_pkg::OP_BACKSPACE: begin
              len_d = len_q - One;
              cur_d = cur_q - One;
            end
            lebc_pkg::OP_DELETE: begin
              len_d = len_q - One;
            end
            lebc_pkg::OP_READ: begin
              chr_n = rdata_i;
            end
            default: begin
              chr_n = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = lebc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_d = res_q;
    ov_d  = ov_q;
    if (load) begin
      res_d.ok         = ok_n;
      res_d.length_out = len_dw[7:0];
      res_d.cursor_out = cur_dw[7:0];
      res_d.char_out   = chr_n;
      ov_d             = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lebc_pkg::ST_IDLE;
      op_q    <= lebc_pkg::OP_CLEAR;
      len_q   <= '0;
      cur_q   <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      ch_q <= char_i;
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/line_edit_buffer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer_core
// One-line text buffer with an edit cursor, driven by one command per
// transaction and answering each with one result transaction.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit up)                      | tuser
//  s_axis   | in        | char_in[7:0], position[15:8]            | opcode[3:0]
//  m_axis   | out       | ok[0], length_out[8:1], cursor_out[16:9], | -
//           |           | char_out[24:17], zero [31:25]           |
//
//  Steps: clear, cursor moves and refused commands load the result on accept;
//  read goes through ST_FIN; insert shifts the bytes from the cursor up, then
//  puts the new byte; delete and backspace shift the later bytes down; one
//  byte is moved per cycle through the single store read/write port pair.
//  Reset: length and cursor clear at once; the store is not cleared.
//  Stalls: a waiting result holds the next command off until it is taken.
// ----------------------------------------------------------------------------
module line_edit_buffer_core #(
  parameter int unsigned BUF_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // char_in[7:0], position[15:8]
  input  logic [3:0]  s_axis_tuser,  // opcode[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // ok, length_out, cursor_out, char_out, pad
);

  localparam int unsigned AW = $clog2(BUF_SIZE);

  lebc_pkg::mem_ctl_t mem_ctl;
  lebc_pkg::result_t  res;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         wdata, rdata;

  lebc_ctrl #(
    .BUF_SIZE (BUF_SIZE),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .char_i      (s_axis_tdata[7:0]),
    .pos_i       (s_axis_tdata[15:8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  lebc_store #(
    .DEPTH (BUF_SIZE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

// ----- rtl/lebc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lebc_checker
// Port-level checks for the line edit buffer core, bound to the top level.
// ----------------------------------------------------------------------------
module lebc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [3:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("command taken while result stalled");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == lebc_pkg::OP_CLEAR)
    |=> m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[24:1] == 24'd0))
    else $error("clear did not give an empty line");

  a_refused_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:17] == 8'd0)
    else $error("refused command returned a byte");

endmodule

bind line_edit_buffer_core lebc_checker u_lebc_checker (.*);
